@@ design/bbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bbe_pkg;

    localparam int LOG_FRAC = 24;
    localparam int NBINS    = 256;
    localparam int QDEPTH   = 4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       counts;
        logic       closes;
    } t_item;

endpackage
`default_nettype wire

@@ design/bbe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bbe_front
    import bbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last_byte,
    input  wire logic       i_empty_block,
    output logic            o_busy,
    output logic            o_q_valid,
    output t_item           o_q_item,
    input  wire logic       i_q_pop
);

    localparam int PW = $clog2(QDEPTH);

    t_item          r_q [QDEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_fill;
    logic           n_push;
    logic           n_pop;
    t_item          n_item;

    assign o_busy    = (r_fill == (PW+1)'(QDEPTH));
    assign o_q_valid = (r_fill != '0);
    assign o_q_item  = r_q[r_rp];
    assign n_push    = i_start && !o_busy;
    assign n_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_item.byte_value = i_byte_value;
        n_item.counts     = !i_empty_block;
        n_item.closes     = i_empty_block || i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (n_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (n_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!n_push && n_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/bbe_log2.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bbe_log2
    import bbe_pkg::*;
#(
    parameter int CW = 14,
    parameter int KW = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [CW-1:0]        i_x,
    output logic                      o_done,
    output logic [KW+LOG_FRAC-1:0]    o_res
);

    logic                 r_run;
    logic [4:0]           r_it;
    logic [31:0]          r_m;
    logic [LOG_FRAC-1:0]  r_frac;
    logic [KW-1:0]        r_k;
    logic [KW-1:0]        n_k;
    logic [63:0]          n_sq;
    logic [32:0]          n_t;
    logic [31:0]          n_m;
    logic [LOG_FRAC-1:0]  n_frac;

    always_comb begin
        n_k = '0;
        for (int i = 0; i < CW; i++) begin
            if (i_x[i]) begin
                n_k = KW'(i);
            end
        end
        n_sq   = 64'(r_m) * 64'(r_m);
        n_t    = n_sq[63:31];
        n_m    = n_t[32] ? n_t[32:1] : n_t[31:0];
        n_frac = {r_frac[LOG_FRAC-2:0], n_t[32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= n_k;
            r_m    <= 32'(i_x) << (5'd31 - 5'(n_k));
            r_frac <= '0;
        end else if (r_run) begin
            r_m    <= n_m;
            r_frac <= n_frac;
        end
        if (r_run && r_it == 5'(LOG_FRAC - 1)) begin
            o_res <= {r_k, n_frac};
        end
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_it   <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_it  <= '0;
            end else if (r_run) begin
                r_it <= r_it + 1'b1;
                if (r_it == 5'(LOG_FRAC - 1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ design/bbe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bbe_back
    import bbe_pkg::*;
#(
    parameter int MAX_BLOCK = 8192,
    parameter int FRAC_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    output logic [15:0] o_entropy_q4_12,
    output logic [13:0] o_bytes_counted,
    output logic        o_overflowed
);

    localparam int CW   = $clog2(MAX_BLOCK + 1);
    localparam int KW   = $clog2(CW);
    localparam int LW   = KW + LOG_FRAC;
    localparam int PW   = CW + LW;
    localparam int DW   = $clog2(PW + 1);
    localparam int SH   = LOG_FRAC - FRAC_BITS;
    localparam int CAPF = 8 << FRAC_BITS;
    localparam int CAP  = (CAPF > 65535) ? 65535 : CAPF;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INC  = 4'd1;
    localparam logic [3:0] S_FIN  = 4'd2;
    localparam logic [3:0] S_LOG  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_SUB  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [CW-1:0]    r_hist [NBINS];
    logic [NBINS-1:0] r_hval;
    logic [CW-1:0]    r_rdat;
    logic [7:0]       n_rd_addr;
    logic             n_we;
    logic [CW-1:0]    n_cnt;

    logic [3:0]       r_state;
    logic [7:0]       r_addr;
    logic             r_close;
    logic [CW-1:0]    r_total;
    logic             r_drop;
    logic [8:0]       r_bin;
    logic [CW-1:0]    r_mx;
    logic             r_isn;
    logic [PW-1:0]    r_prod;
    logic [PW-1:0]    r_whole;
    logic [PW-1:0]    r_sum;
    logic [PW-1:0]    r_quo;
    logic [CW-1:0]    r_rem;
    logic [DW-1:0]    r_dcnt;

    logic             n_log_start;
    logic [CW-1:0]    n_log_x;
    logic             log_done;
    logic [LW-1:0]    log_res;
    logic [CW-1:0]    n_binc;
    logic [CW:0]      n_rsh;
    logic [PW:0]      n_rnd;
    logic [PW-SH:0]   n_out;
    logic [31:0]      n_tot32;
    logic [13:0]      n_cnt14;

    bbe_log2 #(.CW(CW), .KW(KW)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_log_start),
        .i_x     (n_log_x),
        .o_done  (log_done),
        .o_res   (log_res)
    );

    always_comb begin
        o_q_pop     = (r_state == S_IDLE) && i_q_valid;
        n_rd_addr   = (r_state == S_IDLE) ? i_q_item.byte_value : r_bin[7:0];
        n_we        = (r_state == S_INC);
        n_cnt       = (r_hval[r_addr] ? r_rdat : '0) + 1'b1;
        n_binc      = r_hval[r_bin[7:0]] ? r_rdat : '0;
        n_log_start = (r_state == S_FIN && r_total != '0)
                   || (r_state == S_CHK && n_binc != '0);
        n_log_x     = (r_state == S_FIN) ? r_total : n_binc;
        n_rsh       = {r_rem, r_quo[PW-1]};
        n_rnd       = (PW+1)'(r_quo) + (PW+1)'(1 << (SH - 1));
        n_out       = n_rnd[PW:SH];
        n_tot32     = 32'(r_total);
        n_cnt14     = (n_tot32 > 32'h3FFF) ? 14'h3FFF : n_tot32[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_hist[r_addr] <= n_cnt;
        end
        r_rdat <= r_hist[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hval  <= '0;
            r_total <= '0;
            r_drop  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_addr  <= i_q_item.byte_value;
                        r_close <= i_q_item.closes;
                        if (i_q_item.counts && r_total < CW'(MAX_BLOCK)) begin
                            r_state <= S_INC;
                        end else begin
                            if (i_q_item.counts) begin
                                r_drop <= 1'b1;
                            end
                            if (i_q_item.closes) begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_INC: begin
                    r_hval[r_addr] <= 1'b1;
                    r_total        <= r_total + 1'b1;
                    r_state        <= r_close ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_sum <= '0;
                    r_mx  <= r_total;
                    r_isn <= 1'b1;
                    if (r_total == '0) begin
                        r_quo   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    if (log_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(r_mx) * PW'(log_res);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_isn) begin
                        r_whole <= r_prod;
                        r_bin   <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_sum <= r_sum + r_prod;
                        r_bin <= r_bin + 1'b1;
                        r_state <= (r_bin == 9'(NBINS - 1)) ? S_SUB : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_mx  <= n_binc;
                    r_isn <= 1'b0;
                    if (n_binc != '0) begin
                        r_state <= S_LOG;
                    end else begin
                        r_bin <= r_bin + 1'b1;
                        r_state <= (r_bin == 9'(NBINS - 1)) ? S_SUB : S_RD;
                    end
                end
                S_SUB: begin
                    r_quo   <= (r_whole > r_sum) ? (r_whole - r_sum) : '0;
                    r_rem   <= '0;
                    r_dcnt  <= DW'(PW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_dcnt <= r_dcnt - 1'b1;
                        if (n_rsh >= {1'b0, r_total}) begin
                            r_rem <= CW'(n_rsh - {1'b0, r_total});
                            r_quo <= {r_quo[PW-2:0], 1'b1};
                        end else begin
                            r_rem <= n_rsh[CW-1:0];
                            r_quo <= {r_quo[PW-2:0], 1'b0};
                        end
                    end
                end
                S_OUT: begin
                    o_valid         <= 1'b1;
                    o_entropy_q4_12 <= (r_total == '0) ? 16'd0
                                     : ((n_out > (PW-SH+1)'(CAP)) ? 16'(CAP)
                                                                   : n_out[15:0]);
                    o_bytes_counted <= n_cnt14;
                    o_overflowed    <= r_drop;
                    r_hval          <= '0;
                    r_total         <= '0;
                    r_drop          <= 1'b0;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/byte_block_entropy.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                 Fields
// request   in         i_start high, o_busy low  i_byte_value, i_last_byte, i_empty_block
// result    out        o_valid for one cycle     o_entropy_q4_12, o_bytes_counted, o_overflowed
//
// A counted byte is read from its bin in the histogram unit and then written back;
// a four-entry queue in front takes requests at one per cycle until it fills.
// Closing a block walks all 256 bins; every non-empty bin goes through the iterative
// log2 unit (24 squarings), and a bit-serial divide follows.
// Reset is synchronous and needs no clearing pass; the histogram is cleared at once
// after each result. The receiver cannot stall; o_busy holds requests off.
module byte_block_entropy
    import bbe_pkg::*;
#(
    parameter int MAX_BLOCK = 8192,
    parameter int FRAC_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    input  wire logic        i_empty_block,
    output logic             o_valid,
    output logic [15:0]      o_entropy_q4_12,
    output logic [13:0]      o_bytes_counted,
    output logic             o_overflowed
);

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    bbe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .i_empty_block (i_empty_block),
        .o_busy        (o_busy),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    bbe_back #(.MAX_BLOCK(MAX_BLOCK), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .o_entropy_q4_12 (o_entropy_q4_12),
        .o_bytes_counted (o_bytes_counted),
        .o_overflowed    (o_overflowed)
    );

endmodule
`default_nettype wire
